/* hdl/ple_pkg.sv */
package ple_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_FIELD_W  = 7;
    localparam int COUNT_W      = 7;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADPOS    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2
    } act_t;

    typedef struct packed {
        op_t                       operation;
        logic [POS_FIELD_W-1:0]    position;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  removed_value;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

    typedef struct packed {
        act_t                      act;
        logic signed [DATA_W-1:0]  value;
    } cmd_t;

endpackage

/* hdl/ple_cell.sv */
module ple_cell #(
    parameter int INDEX = 0,
    parameter int POS_W = 7
) (
    input  logic                              clk,
    input  ple_pkg::cmd_t                     cmd,
    input  logic [POS_W-1:0]                  pos,
    input  logic signed [ple_pkg::DATA_W-1:0] left,
    input  logic signed [ple_pkg::DATA_W-1:0] right,
    output logic signed [ple_pkg::DATA_W-1:0] entry,
    output logic signed [ple_pkg::DATA_W-1:0] tap
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.act)
            ACT_INSERT:
            begin
                if (IDX == pos)
                begin
                    entry_next = cmd.value;
                end
                else if (IDX > pos)
                begin
                    entry_next = left;
                end
            end
            ACT_DELETE:
            begin
                if (IDX >= pos)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign tap   = (cmd.act == ACT_DELETE && IDX == pos) ? entry_reg : '0;

endmodule

/* hdl/ple_ctrl.sv */
module ple_ctrl #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF,
    parameter int POS_W    = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  ple_pkg::req_t                 req,
    output ple_pkg::cmd_t                 cmd,
    output logic [POS_W-1:0]              pos,
    output ple_pkg::status_t              status,
    output logic [POS_W-1:0]              length,
    output logic [ple_pkg::COUNT_W-1:0]   count
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

    logic [POS_W-1:0] length_reg;
    logic [POS_W-1:0] length_next;
    logic [POS_W-1:0] req_pos;
    act_t             act;

    always_comb
    begin
        req_pos = POS_W'(req.position);
        act     = ACT_HOLD;
        pos     = req_pos;
        status  = ST_OK;
        case (req.operation)
            OP_APPEND:
            begin
                if (length_reg >= CAP)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    act = ACT_INSERT;
                    pos = length_reg;
                end
            end
            OP_INSERT:
            begin
                if (length_reg >= CAP)
                begin
                    status = ST_OVERFLOW;
                end
                else if (req_pos > length_reg)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    act = ACT_INSERT;
                end
            end
            OP_DELETE:
            begin
                if (length_reg == '0)
                begin
                    status = ST_UNDERFLOW;
                end
                else if (req_pos >= length_reg)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    act = ACT_DELETE;
                end
            end
            default:
            begin
                act = ACT_HOLD;
            end
        endcase
    end

    always_comb
    begin
        cmd.act   = accept ? act : ACT_HOLD;
        cmd.value = req.value;
        case (cmd.act)
            ACT_INSERT: length_next = length_reg + POS_W'(1);
            ACT_DELETE: length_next = length_reg - POS_W'(1);
            default:    length_next = length_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else
        begin
            length_reg <= length_next;
        end
    end

    assign length = length_reg;
    assign count  = length_next[COUNT_W-1:0];

endmodule

/* hdl/positional_list_engine.sv */
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Request channel (req_valid, req_stall, req): operation append, insert at
// position or delete at position, with position and value. Response channel
// (rsp_valid, rsp_stall, rsp): removed value, status and entry count after
// the request. Every request yields exactly one response.
// The response to an accepted request is registered and shows from the cycle
// after acceptance on. Throughput: one request per cycle unless req_stall is high;
// the whole list shifts in that cycle through the entry cells, one per list place.
// A request waits while a response sits in the output register and the
// receiver stalls; the output register frees as the response is taken, so
// a new request is taken in the same cycle.
// Reset clears the entry count and the response valid; entry storage is not
// cleared and needs no clearing pass.
// Errors (overflow, underflow, invalid position) leave the list unchanged;
// operation code 3 is a no-op returning status ok.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ple_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ple_pkg::rsp_t rsp
);
    import ple_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (LEN_W > POS_FIELD_W) ? LEN_W : POS_FIELD_W;

    logic                     accept;
    cmd_t                     cmd;
    logic [POS_W-1:0]         pos;
    status_t                  status;
    logic [POS_W-1:0]         length;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] entries [CAPACITY];
    logic signed [DATA_W-1:0] taps    [CAPACITY];
    logic signed [DATA_W-1:0] removed;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .POS_W    (POS_W)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cmd    (cmd),
        .pos    (pos),
        .status (status),
        .length (length),
        .count  (count)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;

        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_mid_l
            assign left = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid_r
            assign right = entries[i+1];
        end

        ple_cell #(
            .INDEX (i),
            .POS_W (POS_W)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .pos   (pos),
            .left  (left),
            .right (right),
            .entry (entries[i]),
            .tap   (taps[i])
        );
    end

    always_comb
    begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed = removed | taps[i];
        end
    end

    always_comb
    begin
        rsp_next               = rsp_reg;
        rsp_valid_next         = rsp_valid_reg;
        if (accept)
        begin
            rsp_next.removed_value = removed;
            rsp_next.status        = status;
            rsp_next.count         = count;
            rsp_valid_next         = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length <= POS_W'(CAPACITY))
        else $error("entry count above capacity");

    a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status != ST_OK |=> $stable(length))
        else $error("failed request changed the list");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.act == ACT_INSERT |=> length == $past(length) + POS_W'(1))
        else $error("insert did not grow the list");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.act != ACT_DELETE |-> removed == '0)
        else $error("removed value without a delete");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import ple_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam op_t OP_UNUSED = op_t'(2'd3);
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int list_len = 0;
    rsp_t expected_rsp [$];
    int fail_count = 0;
    bit tx_idle_on = 1'b1;
    bit rx_stall_on = 1'b1;
    int stall_left = 0;

    positional_list_engine #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Mirror one request on the list and return the response it must give.
    function automatic rsp_t list_apply(req_t item);
        rsp_t o;
        int p;
        o.removed_value = '0;
        o.status = ST_OK;
        case (item.operation)
            OP_APPEND, OP_INSERT:
            begin
                p = (item.operation == OP_APPEND) ? list_len : int'(item.position);
                if (list_len >= CAPACITY)
                    o.status = ST_OVERFLOW;
                else if (p > list_len)
                    o.status = ST_BADPOS;
                else
                begin
                    for (int i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[p] = item.value;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                p = int'(item.position);
                if (list_len == 0)
                    o.status = ST_UNDERFLOW;
                else if (p >= list_len)
                    o.status = ST_BADPOS;
                else
                begin
                    o.removed_value = list_mem[p];
                    for (int i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        o.count = COUNT_W'(list_len);
        return o;
    endfunction

    function automatic req_t make_req(op_t op, int pos, logic signed [DATA_W-1:0] val);
        req_t r;
        r.operation = op;
        r.position = POS_FIELD_W'(pos);
        r.value = val;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return INT_MIN;
        else if (r < 6)
            return INT_MAX;
        else if (r < 8)
            return '0;
        else if (r < 10)
            return '1;
        else
            return $urandom;
    endfunction

    task automatic send_item(input req_t item);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsp.push_back(list_apply(item));
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!rx_stall_on || $urandom_range(0, 3) != 0)
            rsp_stall <= 1'b0;
        else
        begin
            rsp_stall <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected response item: %p", rsp);
                fail_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.removed_value !== want.removed_value)
                begin
                    $error("removed_value mismatch: expected %0d, actual %0d",
                           want.removed_value, rsp.removed_value);
                    fail_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %s, actual %0d",
                           want.status.name(), rsp.status);
                    fail_count++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count mismatch: expected %0d, actual %0d",
                           want.count, rsp.count);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_item(make_req(OP_DELETE, 0, 0));
        send_item(make_req(OP_DELETE, 127, 0));
        send_item(make_req(OP_UNUSED, 5, INT_MAX));
        send_item(make_req(OP_INSERT, 1, 7));
        send_item(make_req(OP_APPEND, 99, INT_MIN));
        send_item(make_req(OP_APPEND, 0, INT_MAX));
        send_item(make_req(OP_INSERT, 2, 0));
        send_item(make_req(OP_INSERT, 0, -1));
        send_item(make_req(OP_INSERT, 2, 32'sh5555_AAAA));
        send_item(make_req(OP_INSERT, 6, 3));
        send_item(make_req(OP_INSERT, 127, 3));
        send_item(make_req(OP_DELETE, 5, 0));
        send_item(make_req(OP_DELETE, 64, 0));
        send_item(make_req(OP_DELETE, 2, 0));
        send_item(make_req(OP_UNUSED, 0, 1));
        send_item(make_req(OP_DELETE, 0, 0));
        send_item(make_req(OP_DELETE, 2, 0));
        send_item(make_req(OP_DELETE, 0, 0));
        send_item(make_req(OP_DELETE, 0, 0));
        send_item(make_req(OP_DELETE, 0, 0));
        wait_drain();
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(make_req(OP_APPEND, $urandom_range(0, 127), pick_value()));
            else
                send_item(make_req(OP_INSERT, $urandom_range(0, list_len), pick_value()));
        end
        send_item(make_req(OP_APPEND, 0, pick_value()));
        send_item(make_req(OP_INSERT, 0, pick_value()));
        send_item(make_req(OP_INSERT, 127, pick_value()));
        send_item(make_req(OP_DELETE, CAPACITY, 0));
        send_item(make_req(OP_DELETE, CAPACITY - 1, 0));
        send_item(make_req(OP_INSERT, CAPACITY - 1, pick_value()));
        while (list_len > 0)
            send_item(make_req(OP_DELETE, $urandom_range(0, list_len - 1), 0));
        send_item(make_req(OP_DELETE, 100, 0));
        wait_drain();
    endtask

    task automatic test_random_mix(input int n);
        bit grow;
        int r;
        int pos;
        op_t op;
        grow = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            if (k % 100 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            if (list_len == CAPACITY || $urandom_range(0, 49) == 0)
                grow = 1'b0;
            if (list_len == 0)
                grow = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < (grow ? 50 : 20))
                op = OP_APPEND;
            else if (r < (grow ? 80 : 40))
                op = OP_INSERT;
            else
                op = OP_DELETE;
            if ($urandom_range(0, 99) < 15)
                pos = $urandom_range(0, 127);
            else if (op == OP_DELETE)
                pos = (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
            else
                pos = $urandom_range(0, list_len);
            send_item(make_req(op, pos, pick_value()));
        end
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
        wait_drain();
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 20; k++)
        begin
            wait_drain();
            if (list_len > 0 && $urandom_range(0, 1) == 0)
                send_item(make_req(OP_DELETE, $urandom_range(0, list_len - 1), 0));
            else
                send_item(make_req(OP_INSERT, $urandom_range(0, list_len), pick_value()));
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_list();
        test_drain_pause();
        test_random_mix(700);
        test_full_list();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
